// ----- rtl/attp_pkg.sv -----
`default_nettype none

package attp_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_FG_BASE       = 3'd0;
   localparam logic [2:0] CSR_BG_BASE       = 3'd1;
   localparam logic [2:0] CSR_MARGIN_X      = 3'd2;
   localparam logic [2:0] CSR_GLYPH_PITCH   = 3'd3;
   localparam logic [2:0] CSR_LINE_ADVANCE  = 3'd4;
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd5;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd6;
   localparam logic [2:0] CSR_CRLF_MODE     = 3'd7;

   // Reset values of the configuration registers
   localparam logic [15:0] RST_FG_BASE       = 16'hFFFF;
   localparam logic [15:0] RST_BG_BASE       = 16'h0000;
   localparam logic [9:0]  RST_MARGIN_X      = 10'd0;
   localparam logic [5:0]  RST_GLYPH_PITCH   = 6'd8;
   localparam logic [5:0]  RST_LINE_ADVANCE  = 6'd10;
   localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd640;
   localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd480;
   localparam logic        RST_CRLF_MODE     = 1'b0;

   localparam logic [10:0] SCREEN_MAX = 11'd1024;
   localparam logic [6:0]  PVAL_MAX   = 7'd127;

   // Character codes
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_SGR_END   = 8'h6D;

   // SGR codes
   localparam logic [6:0] SGR_RESET   = 7'd0;
   localparam logic [6:0] SGR_BRIGHT  = 7'd1;
   localparam logic [6:0] SGR_DIM     = 7'd2;
   localparam logic [6:0] SGR_INVERSE = 7'd7;
   localparam logic [6:0] SGR_FG_LO   = 7'd30;
   localparam logic [6:0] SGR_FG_HI   = 7'd37;
   localparam logic [6:0] SGR_BG_LO   = 7'd40;
   localparam logic [6:0] SGR_BG_HI   = 7'd47;

   localparam logic [3:0] GRAY_BRIGHT = 4'd12;
   localparam logic [3:0] GRAY_DIM    = 4'd4;

   localparam logic KIND_DRAW   = 1'b0;
   localparam logic KIND_SCROLL = 1'b1;

   typedef enum logic [2:0] {
      ST_TEXT = 3'b001,
      ST_ESC  = 3'b010,
      ST_CSI  = 3'b100
   } attp_pstate_type;

   typedef struct packed {
      logic [15:0] fg_base;
      logic [15:0] bg_base;
      logic [9:0]  margin_x;
      logic [5:0]  glyph_pitch;
      logic [5:0]  line_advance;
      logic [10:0] screen_width;
      logic [10:0] screen_height;
      logic        crlf_mode;
   } attp_cfg_type;

   typedef struct packed {
      logic        kind;
      logic [9:0]  pos_x;
      logic [9:0]  pos_y;
      logic [7:0]  glyph;
      logic [15:0] fore_colour;
      logic [15:0] back_colour;
      logic [5:0]  scroll_rows;
      logic        last;
   } attp_result_type;

   typedef struct packed {
      logic [15:0] fg;
      logic [15:0] bg;
   } attp_colors_type;

   // RGB565 grey from a 4-bit level
   function automatic logic [15:0] attp_gray16(input logic [3:0] n);
      logic [4:0] rb;
      logic [5:0] g;
      rb = {n, n[3]};
      g  = {n, n[3:2]};
      return {rb, g, rb};
   endfunction

   function automatic attp_colors_type attp_apply_code(
      input logic [6:0]      code,
      input attp_colors_type cur,
      input logic [15:0]     dfg,
      input logic [15:0]     dbg
   );
      attp_colors_type res;
      logic [6:0]      off;
      res = cur;
      off = 7'd0;
      if (code == SGR_RESET) begin
         res.fg = dfg;
         res.bg = dbg;
      end else if (code == SGR_INVERSE) begin
         res.fg = cur.bg;
         res.bg = cur.fg;
      end else if (code == SGR_BRIGHT) begin
         res.fg = attp_gray16(GRAY_BRIGHT);
      end else if (code == SGR_DIM) begin
         res.fg = attp_gray16(GRAY_DIM);
      end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
         off    = code - SGR_FG_LO;
         res.fg = attp_gray16({off[2:0], 1'b0});
      end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
         off    = code - SGR_BG_LO;
         res.bg = attp_gray16({off[2:0], 1'b0});
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/attp_step.sv -----
`default_nettype none

module attp_step #(
   parameter int PARAM_BUF_BYTES = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire attp_pkg::attp_cfg_type    cfg,
   input  wire logic                      go,
   input  wire logic [7:0]                ch,
   output logic [1:0]                     res_cnt,
   output attp_pkg::attp_result_type      res0,
   output attp_pkg::attp_result_type      res1
);
   import attp_pkg::*;

   localparam int PC_W   = $clog2(PARAM_BUF_BYTES);
   localparam int PC_MAX = PARAM_BUF_BYTES - 1;

   logic [9:0]      cur_x_ff, cur_x_in;
   logic [9:0]      cur_y_ff, cur_y_in;
   logic [15:0]     fg_ff, fg_in;
   logic [15:0]     bg_ff, bg_in;
   attp_pstate_type pstate_ff, pstate_in;
   logic [PC_W-1:0] pchars_ff, pchars_in;
   logic [6:0]      pval_ff, pval_in;
   logic            popen_ff, popen_in;
   logic [15:0]     sh_fg_ff, sh_fg_in;
   logic [15:0]     sh_bg_ff, sh_bg_in;

   logic [10:0]     w_lim, h_lim;
   logic [10:0]     x_adv, y_adv, bs_lim, pv_mul;
   logic            wrap, bottom, bs_clamp, digit;
   attp_colors_type applied;
   attp_result_type draw_res, scroll_res;

   always_comb begin
      w_lim    = (cfg.screen_width > SCREEN_MAX) ? SCREEN_MAX : cfg.screen_width;
      h_lim    = (cfg.screen_height > SCREEN_MAX) ? SCREEN_MAX : cfg.screen_height;
      x_adv    = {1'b0, cur_x_ff} + {5'b0, cfg.glyph_pitch};
      y_adv    = {1'b0, cur_y_ff} + {5'b0, cfg.line_advance};
      bs_lim   = {1'b0, cfg.margin_x} + {5'b0, cfg.glyph_pitch};
      wrap     = x_adv >= w_lim;
      bottom   = y_adv >= h_lim;
      bs_clamp = {1'b0, cur_x_ff} < bs_lim;
      digit    = ch >= CH_ZERO && ch <= CH_NINE;
      pv_mul   = {1'b0, pval_ff, 3'b000} + {3'b000, pval_ff, 1'b0} + {7'b0, ch[3:0]};
      applied  = attp_apply_code(pval_ff, '{fg: sh_fg_ff, bg: sh_bg_ff},
                                 cfg.fg_base, cfg.bg_base);

      draw_res.kind        = KIND_DRAW;
      draw_res.pos_x       = cur_x_ff;
      draw_res.pos_y       = cur_y_ff;
      draw_res.glyph       = ch;
      draw_res.fore_colour = fg_ff;
      draw_res.back_colour = bg_ff;
      draw_res.scroll_rows = 6'd0;
      draw_res.last        = 1'b1;

      scroll_res.kind        = KIND_SCROLL;
      scroll_res.pos_x       = 10'd0;
      scroll_res.pos_y       = 10'd0;
      scroll_res.glyph       = 8'd0;
      scroll_res.fore_colour = 16'd0;
      scroll_res.back_colour = cfg.bg_base;
      scroll_res.scroll_rows = cfg.line_advance;
      scroll_res.last        = 1'b1;

      res_cnt   = 2'd0;
      res0      = draw_res;
      res1      = scroll_res;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      fg_in     = fg_ff;
      bg_in     = bg_ff;
      pstate_in = pstate_ff;
      pchars_in = pchars_ff;
      pval_in   = pval_ff;
      popen_in  = popen_ff;
      sh_fg_in  = sh_fg_ff;
      sh_bg_in  = sh_bg_ff;

      case (pstate_ff)
         ST_ESC: begin
            if (ch == CH_LBRACKET) begin
               pstate_in = ST_CSI;
               pchars_in = '0;
               pval_in   = 7'd0;
               popen_in  = 1'b0;
               sh_fg_in  = fg_ff;
               sh_bg_in  = bg_ff;
            end else begin
               pstate_in = ST_TEXT;
            end
         end
         ST_CSI: begin
            if (digit || ch == CH_SEMICOLON) begin
               // drop parameter characters beyond the buffer
               if (pchars_ff < PC_W'(PC_MAX)) begin
                  pchars_in = pchars_ff + PC_W'(1);
                  if (digit) begin
                     pval_in  = (pv_mul > {4'b0, PVAL_MAX}) ? PVAL_MAX : pv_mul[6:0];
                     popen_in = 1'b1;
                  end else begin
                     sh_fg_in = applied.fg;
                     sh_bg_in = applied.bg;
                     pval_in  = 7'd0;
                     popen_in = 1'b0;
                  end
               end
            end else begin
               if (ch == CH_SGR_END) begin
                  fg_in = popen_ff ? applied.fg : sh_fg_ff;
                  bg_in = popen_ff ? applied.bg : sh_bg_ff;
               end
               pstate_in = ST_TEXT;
            end
         end
         default: begin
            pstate_in = ST_TEXT;
            if (ch == CH_ESC) begin
               pstate_in = ST_ESC;
            end else if (ch >= CH_SPACE) begin
               res_cnt = 2'd1;
               if (wrap) begin
                  cur_x_in = cfg.margin_x;
                  if (bottom) begin
                     res_cnt       = 2'd2;
                     res0.last     = 1'b0;
                  end else begin
                     cur_y_in = y_adv[9:0];
                  end
               end else begin
                  cur_x_in = x_adv[9:0];
               end
            end else if (ch == CH_BS) begin
               cur_x_in = bs_clamp ? cfg.margin_x : (cur_x_ff - {4'b0, cfg.glyph_pitch});
            end else if (ch == CH_CR || (ch == CH_LF && !cfg.crlf_mode)) begin
               cur_x_in = cfg.margin_x;
               if (bottom) begin
                  res_cnt = 2'd1;
                  res0    = scroll_res;
               end else begin
                  cur_y_in = y_adv[9:0];
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= RST_MARGIN_X;
         cur_y_ff  <= 10'd0;
         fg_ff     <= RST_FG_BASE;
         bg_ff     <= RST_BG_BASE;
         pstate_ff <= ST_TEXT;
         pchars_ff <= '0;
         pval_ff   <= 7'd0;
         popen_ff  <= 1'b0;
         sh_fg_ff  <= 16'd0;
         sh_bg_ff  <= 16'd0;
      end else if (go) begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         fg_ff     <= fg_in;
         bg_ff     <= bg_in;
         pstate_ff <= pstate_in;
         pchars_ff <= pchars_in;
         pval_ff   <= pval_in;
         popen_ff  <= popen_in;
         sh_fg_ff  <= sh_fg_in;
         sh_bg_ff  <= sh_bg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/attp_outq.sv -----
`default_nettype none

module attp_outq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [1:0]                push_cnt,
   input  wire attp_pkg::attp_result_type res0,
   input  wire attp_pkg::attp_result_type res1,
   input  wire logic                      rsp_stall,
   output logic                           rsp_valid,
   output attp_pkg::attp_result_type      head,
   output logic [1:0]                     room
);
   import attp_pkg::*;

   attp_result_type q0_ff, q0_in;
   attp_result_type q1_ff, q1_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [1:0]      base_cnt;
   logic            pop;

   always_comb begin
      pop      = (cnt_ff != 2'd0) && !rsp_stall;
      base_cnt = cnt_ff - {1'b0, pop};
      room     = 2'd2 - base_cnt;
      // advance the second entry to the head on a pop, then append
      q0_in    = pop ? q1_ff : q0_ff;
      q1_in    = q1_ff;
      case (base_cnt)
         2'd0: begin
            q0_in = res0;
            q1_in = res1;
         end
         2'd1: begin
            q1_in = res0;
         end
         default: begin
         end
      endcase
      cnt_in = base_cnt + push_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_valid = cnt_ff != 2'd0;
   assign head      = q0_ff;

endmodule

`default_nettype wire

// ----- rtl/ansi_text_terminal_parser_core.sv -----
`default_nettype none

// Byte-stream terminal parser: each accepted byte moves the cursor, updates the
// ANSI SGR colour state, and yields zero, one or two result items (glyph draw,
// scroll, or a draw followed by a scroll when the wrap lands on the bottom line).
// A byte is registered on accept and, once the queue has room for all its
// results, resolved into a two-entry result queue whose head drives the single
// result port. Bytes that give at most one result are taken every cycle while
// the result side does not stall; a draw-plus-scroll byte waits until both
// queue entries are free. Config writes are expected only while the block is idle.
module ansi_text_terminal_parser_core #(
   parameter int PARAM_BUF_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [9:0]       rsp_pos_x,
   output logic [9:0]       rsp_pos_y,
   output logic [7:0]       rsp_glyph,
   output logic [15:0]      rsp_fore_colour,
   output logic [15:0]      rsp_back_colour,
   output logic [5:0]       rsp_scroll_rows,
   output logic             rsp_last
);
   import attp_pkg::*;

   attp_cfg_type    cfg_ff, cfg_in;
   logic            in_vld_ff, in_vld_in;
   logic [7:0]      in_ch_ff, in_ch_in;
   logic            go;
   logic [1:0]      res_cnt, push_cnt, room;
   attp_result_type res0, res1, head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FG_BASE:       cfg_in.fg_base       = csr_wdata;
            CSR_BG_BASE:       cfg_in.bg_base       = csr_wdata;
            CSR_MARGIN_X:      cfg_in.margin_x      = csr_wdata[9:0];
            CSR_GLYPH_PITCH:   cfg_in.glyph_pitch   = csr_wdata[5:0];
            CSR_LINE_ADVANCE:  cfg_in.line_advance  = csr_wdata[5:0];
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[10:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[10:0];
            CSR_CRLF_MODE:     cfg_in.crlf_mode     = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_base       <= RST_FG_BASE;
         cfg_ff.bg_base       <= RST_BG_BASE;
         cfg_ff.margin_x      <= RST_MARGIN_X;
         cfg_ff.glyph_pitch   <= RST_GLYPH_PITCH;
         cfg_ff.line_advance  <= RST_LINE_ADVANCE;
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.crlf_mode     <= RST_CRLF_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // resolve the held byte only when the queue has room for all its results
   assign go        = in_vld_ff && (res_cnt <= room);
   assign push_cnt  = go ? res_cnt : 2'd0;
   assign req_stall = in_vld_ff && !go;

   always_comb begin
      in_vld_in = in_vld_ff && !go;
      in_ch_in  = in_ch_ff;
      if (req_valid && !req_stall) begin
         in_vld_in = 1'b1;
         in_ch_in  = req_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff <= in_ch_in;
   end

   attp_step #(
      .PARAM_BUF_BYTES(PARAM_BUF_BYTES)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .go      (go),
      .ch      (in_ch_ff),
      .res_cnt (res_cnt),
      .res0    (res0),
      .res1    (res1)
   );

   attp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .res0      (res0),
      .res1      (res1),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .room      (room)
   );

   assign rsp_kind        = head.kind;
   assign rsp_pos_x       = head.pos_x;
   assign rsp_pos_y       = head.pos_y;
   assign rsp_glyph       = head.glyph;
   assign rsp_fore_colour = head.fore_colour;
   assign rsp_back_colour = head.back_colour;
   assign rsp_scroll_rows = head.scroll_rows;
   assign rsp_last        = head.last;

   a_res_cnt_range: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff |-> res_cnt != 2'd3)
      else $error("more than two results for one byte");

   a_draw_then_scroll: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_kind == KIND_DRAW && !rsp_last) |=>
      (rsp_valid && rsp_kind == KIND_SCROLL && rsp_last))
      else $error("non-final draw not followed by its scroll");

   a_scroll_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_SCROLL) |-> (rsp_last && rsp_glyph == 8'd0))
      else $error("scroll result is not final or carries a glyph");

   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (in_vld_ff && $stable(in_ch_ff)))
      else $error("held byte lost while stalled");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import attp_pkg::*;

   localparam int PARAM_BUF_BYTES = 8;
   localparam int PARAM_KEEP      = PARAM_BUF_BYTES - 1;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_CYCLES     = 250;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int NROW            = 30;
   localparam int NUM_PHASES      = 10;

   typedef enum logic [1:0] {ROW_PRED, ROW_QUIET, ROW_DRAW} row_chk_type;

   typedef struct packed {
      logic [7:0]  ch;
      row_chk_type chk;
      logic [9:0]  x;
      logic [9:0]  y;
      logic [15:0] fg;
      logic [15:0] bg;
   } script_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        csr_we    = 1'b0;
   logic [2:0]  csr_index = CSR_FG_BASE;
   logic [15:0] csr_wdata = 16'h0000;
   logic        req_valid = 1'b0;
   logic [7:0]  req_ch    = 8'h00;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_kind;
   logic [9:0]  rsp_pos_x;
   logic [9:0]  rsp_pos_y;
   logic [7:0]  rsp_glyph;
   logic [15:0] rsp_fore_colour;
   logic [15:0] rsp_back_colour;
   logic [5:0]  rsp_scroll_rows;
   logic        rsp_last;

   ansi_text_terminal_parser_core #(
      .PARAM_BUF_BYTES(PARAM_BUF_BYTES)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_glyph      (rsp_glyph),
      .rsp_fore_colour(rsp_fore_colour),
      .rsp_back_colour(rsp_back_colour),
      .rsp_scroll_rows(rsp_scroll_rows),
      .rsp_last       (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Terminal state mirrored by the testbench
   attp_cfg_type    setup;
   attp_pstate_type pmode;
   int unsigned     cur_x, cur_y, pchars, pval;
   bit              popen;
   logic [15:0]     fg_cur, bg_cur, sh_fg, sh_bg;

   attp_result_type awaited_ops[$];
   logic [7:0]      burst_q[$];

   int unsigned cycle_cnt   = 0;
   int          err_cnt     = 0;
   int          bytes_sent  = 0;
   int          draws_seen  = 0;
   int          scrolls_seen = 0;
   int          setups_used = 0;
   int          send_pct    = 0;
   bit          idle_on     = 1'b1;
   bit          hold_req    = 1'b0;

   // Directed opening: reset setup, so the simple draws can be read off directly
   script_row_type script [NROW] = '{
      '{8'h41,        ROW_DRAW,  10'd0,  10'd0,  16'hFFFF, 16'h0000},
      '{8'hFF,        ROW_DRAW,  10'd8,  10'd0,  16'hFFFF, 16'h0000},
      '{8'h7F,        ROW_DRAW,  10'd16, 10'd0,  16'hFFFF, 16'h0000},
      '{CH_SPACE,     ROW_DRAW,  10'd24, 10'd0,  16'hFFFF, 16'h0000},
      '{8'h1F,        ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{8'h00,        ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_BS,        ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{8'h61,        ROW_PRED,  10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_CR,        ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_LF,        ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_ESC,       ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{8'h58,        ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_ESC,       ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_LBRACKET,  ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{8'h37,        ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_SGR_END,   ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{8'h42,        ROW_DRAW,  10'd0,  10'd20, 16'h0000, 16'hFFFF},
      '{CH_ESC,       ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_LBRACKET,  ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_ZERO,      ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_ZERO,      ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_ZERO,      ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_ZERO,      ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_ZERO,      ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{8'h34,        ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_ZERO,      ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{8'h33,        ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{CH_SGR_END,   ROW_QUIET, 10'd0,  10'd0,  16'h0000, 16'h0000},
      '{8'h43,        ROW_PRED,  10'd0,  10'd0,  16'h0000, 16'h0000},
      '{8'h80,        ROW_PRED,  10'd0,  10'd0,  16'h0000, 16'h0000}
   };

   function automatic logic [15:0] grey565(input int unsigned n);
      int unsigned rb, g;
      rb = ((n << 1) | (n >> 3)) & 31;
      g  = ((n << 2) | (n >> 2)) & 63;
      return 16'((rb << 11) | (g << 5) | rb);
   endfunction

   function automatic void apply_sgr(input int unsigned code);
      logic [15:0] t;
      if (code == SGR_RESET) begin
         sh_fg = setup.fg_base;
         sh_bg = setup.bg_base;
      end else if (code == SGR_INVERSE) begin
         t     = sh_fg;
         sh_fg = sh_bg;
         sh_bg = t;
      end else if (code == SGR_BRIGHT) begin
         sh_fg = grey565(GRAY_BRIGHT);
      end else if (code == SGR_DIM) begin
         sh_fg = grey565(GRAY_DIM);
      end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
         sh_fg = grey565((code - SGR_FG_LO) * 2);
      end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
         sh_bg = grey565((code - SGR_BG_LO) * 2);
      end
   endfunction

   function automatic void add_op(input logic kind, input int unsigned x, input int unsigned y,
                                  input logic [7:0] g, input logic [15:0] fg,
                                  input logic [15:0] bg, input logic [5:0] rows);
      attp_result_type r;
      r.kind        = kind;
      r.pos_x       = 10'(x);
      r.pos_y       = 10'(y);
      r.glyph       = g;
      r.fore_colour = fg;
      r.back_colour = bg;
      r.scroll_rows = rows;
      r.last        = 1'b0;
      awaited_ops.push_back(r);
   endfunction

   function automatic void break_line();
      int unsigned h, y;
      h = (setup.screen_height > SCREEN_MAX) ? SCREEN_MAX : setup.screen_height;
      y = cur_y + setup.line_advance;
      cur_x = setup.margin_x;
      if (y >= h)
         add_op(KIND_SCROLL, 0, 0, 8'h00, 16'h0000, setup.bg_base, setup.line_advance);
      else
         cur_y = y;
   endfunction

   function automatic void reset_terminal();
      setup = '{RST_FG_BASE, RST_BG_BASE, RST_MARGIN_X, RST_GLYPH_PITCH,
                RST_LINE_ADVANCE, RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_CRLF_MODE};
      cur_x  = RST_MARGIN_X;
      cur_y  = 0;
      fg_cur = RST_FG_BASE;
      bg_cur = RST_BG_BASE;
      pmode  = ST_TEXT;
      pchars = 0;
      pval   = 0;
      popen  = 1'b0;
      sh_fg  = 16'h0000;
      sh_bg  = 16'h0000;
   endfunction

   // Advance the terminal by one byte; queue the draws and scrolls it causes
   function automatic int emulate_byte(input logic [7:0] c);
      int          n0;
      int unsigned w, x;
      bit          dig;
      n0  = awaited_ops.size();
      dig = (c >= CH_ZERO && c <= CH_NINE);
      case (pmode)
         ST_ESC: begin
            if (c == CH_LBRACKET) begin
               pmode  = ST_CSI;
               pchars = 0;
               pval   = 0;
               popen  = 1'b0;
               sh_fg  = fg_cur;
               sh_bg  = bg_cur;
            end else begin
               pmode = ST_TEXT;
            end
         end
         ST_CSI: begin
            if (dig || c == CH_SEMICOLON) begin
               // characters past the buffer are dropped, the sequence goes on
               if (pchars < PARAM_KEEP) begin
                  pchars++;
                  if (dig) begin
                     pval  = pval * 10 + (c - CH_ZERO);
                     if (pval > PVAL_MAX)
                        pval = PVAL_MAX;
                     popen = 1'b1;
                  end else begin
                     apply_sgr(pval);
                     pval  = 0;
                     popen = 1'b0;
                  end
               end
            end else begin
               if (c == CH_SGR_END) begin
                  if (popen)
                     apply_sgr(pval);
                  fg_cur = sh_fg;
                  bg_cur = sh_bg;
               end
               pmode = ST_TEXT;
            end
         end
         default: begin
            pmode = ST_TEXT;
            if (c == CH_ESC) begin
               pmode = ST_ESC;
            end else if (c >= CH_SPACE) begin
               w = (setup.screen_width > SCREEN_MAX) ? SCREEN_MAX : setup.screen_width;
               add_op(KIND_DRAW, cur_x, cur_y, c, fg_cur, bg_cur, 6'd0);
               x = cur_x + setup.glyph_pitch;
               if (x >= w)
                  break_line();
               else
                  cur_x = x;
            end else if (c == CH_BS) begin
               if (cur_x < setup.margin_x + setup.glyph_pitch)
                  cur_x = setup.margin_x;
               else
                  cur_x = cur_x - setup.glyph_pitch;
            end else if (c == CH_CR) begin
               break_line();
            end else if (c == CH_LF && !setup.crlf_mode) begin
               break_line();
            end
         end
      endcase
      if (awaited_ops.size() > n0)
         awaited_ops[$].last = 1'b1;
      return awaited_ops.size() - n0;
   endfunction

   function automatic void push_number(input int unsigned v);
      logic [7:0] digs[$];
      do begin
         digs.push_front(CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      if ($urandom_range(0, 7) == 0)
         digs.push_front(CH_ZERO);
      foreach (digs[i])
         burst_q.push_back(digs[i]);
   endfunction

   // Mostly text and well-formed SGR sequences, some controls and broken escapes
   function automatic void build_burst();
      int roll, np;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         repeat ($urandom_range(1, 8))
            burst_q.push_back(8'($urandom_range(32, 255)));
      end else if (roll < 72) begin
         burst_q.push_back(CH_ESC);
         burst_q.push_back(CH_LBRACKET);
         np = $urandom_range(0, 4);
         for (int i = 0; i < np; i++) begin
            if (i > 0)
               burst_q.push_back(CH_SEMICOLON);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: push_number($urandom_range(SGR_FG_LO, SGR_FG_HI));
               4, 5: push_number($urandom_range(SGR_BG_LO, SGR_BG_HI));
               6: begin
                  case ($urandom_range(0, 3))
                     0: push_number(SGR_RESET);
                     1: push_number(SGR_BRIGHT);
                     2: push_number(SGR_DIM);
                     default: push_number(SGR_INVERSE);
                  endcase
               end
               7: push_number($urandom_range(0, 127));
               8: push_number($urandom_range(128, 999));
               default: ;
            endcase
         end
         if (np > 0 && $urandom_range(0, 5) == 0)
            burst_q.push_back(CH_SEMICOLON);
         burst_q.push_back(CH_SGR_END);
      end else if (roll < 84) begin
         case ($urandom_range(0, 3))
            0: burst_q.push_back(CH_CR);
            1: burst_q.push_back(CH_LF);
            2: burst_q.push_back(CH_BS);
            default: burst_q.push_back(8'($urandom_range(0, 31)));
         endcase
      end else if (roll < 92) begin
         burst_q.push_back(CH_ESC);
         if ($urandom_range(0, 1) == 0) begin
            burst_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            burst_q.push_back(CH_LBRACKET);
            push_number($urandom_range(0, 60));
            burst_q.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         burst_q.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic attp_cfg_type roll_setup();
      attp_cfg_type s;
      s.fg_base       = 16'($urandom);
      s.bg_base       = 16'($urandom);
      s.margin_x      = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                                     : 10'($urandom_range(0, 40));
      s.glyph_pitch   = 6'($urandom_range(1, 63));
      s.line_advance  = 6'($urandom_range(1, 63));
      s.screen_width  = ($urandom_range(0, 7) == 0) ? SCREEN_MAX
                                                     : 11'($urandom_range(1, 320));
      s.screen_height = 11'($urandom_range(1, 240));
      s.crlf_mode     = 1'($urandom_range(0, 1));
      return s;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("mismatch @%0d: %s", cycle_cnt, msg);
      err_cnt++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   task automatic csr_put(input logic [2:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_setup(input attp_cfg_type s);
      csr_put(CSR_FG_BASE,       s.fg_base);
      csr_put(CSR_BG_BASE,       s.bg_base);
      csr_put(CSR_MARGIN_X,      16'(s.margin_x));
      csr_put(CSR_GLYPH_PITCH,   16'(s.glyph_pitch));
      csr_put(CSR_LINE_ADVANCE,  16'(s.line_advance));
      csr_put(CSR_SCREEN_WIDTH,  16'(s.screen_width));
      csr_put(CSR_SCREEN_HEIGHT, 16'(s.screen_height));
      csr_put(CSR_CRLF_MODE,     16'(s.crlf_mode));
      csr_we <= 1'b0;
      setup = s;
      setups_used++;
   endtask

   // Offer one byte, hold it until taken, then update the mirror
   task automatic push_char(input logic [7:0] c, output int made);
      if (bytes_sent % 64 == 0)
         case ($urandom_range(0, 2))
            0: send_pct = 0;
            1: send_pct = 10;
            default: send_pct = 30;
         endcase
      if (idle_on && $urandom_range(1, 100) <= send_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      made = emulate_byte(c);
   endtask

   task automatic sender_pause();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_ops.size() != 0);
   endtask

   task automatic end_phase();
      sender_pause();
      // a trailing byte may cause no result yet still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic feed_random(input int count, input int pause_at);
      int done, made;
      done = 0;
      while (done < count || burst_q.size() != 0) begin
         if (burst_q.size() == 0)
            build_burst();
         push_char(burst_q.pop_front(), made);
         done++;
         if (done == pause_at)
            sender_pause();
      end
   endtask

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   // Result side: random stall bursts, one long hold-off on request
   initial begin
      int tick, pct;
      tick = 0;
      pct  = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 64 == 0)
            case ($urandom_range(0, 2))
               0: pct = 0;
               1: pct = 10;
               default: pct = 30;
            endcase
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(1, 100) <= pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      attp_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_kind, rsp_pos_x, rsp_pos_y, rsp_glyph, rsp_fore_colour,
                 rsp_back_colour, rsp_scroll_rows, rsp_last};
         if (got.kind == KIND_SCROLL)
            scrolls_seen++;
         else
            draws_seen++;
         if (awaited_ops.size() == 0) begin
            flag_mismatch($sformatf("result with nothing pending, kind %0d", got.kind));
         end else begin
            want = awaited_ops.pop_front();
            check_field("kind",        got.kind,        want.kind);
            check_field("pos_x",       got.pos_x,       want.pos_x);
            check_field("pos_y",       got.pos_y,       want.pos_y);
            check_field("glyph",       got.glyph,       want.glyph);
            check_field("fore_colour", got.fore_colour, want.fore_colour);
            check_field("back_colour", got.back_colour, want.back_colour);
            check_field("scroll_rows", got.scroll_rows, want.scroll_rows);
            check_field("last",        got.last,        want.last);
         end
      end
   end

   initial begin
      wait (cycle_cnt >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, awaited_ops.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      attp_cfg_type    s;
      attp_result_type r;
      int              made, count, pause_at;
      reset_terminal();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         push_char(script[i].ch, made);
         if (script[i].chk != ROW_PRED) begin
            // swap the mirrored results for the typed-in ones
            repeat (made) void'(awaited_ops.pop_back());
            if (script[i].chk == ROW_DRAW) begin
               r = '{KIND_DRAW, script[i].x, script[i].y, script[i].ch, script[i].fg,
                     script[i].bg, 6'd0, 1'b1};
               awaited_ops.push_back(r);
            end
         end
      end
      end_phase();

      for (int ph = 1; ph < NUM_PHASES; ph++) begin
         pause_at = -1;
         count    = 220;
         case (ph)
            1: begin
               s = roll_setup();
               s.screen_width  = 11'd200;
               s.screen_height = 11'd60;
               count    = 300;
               hold_req = 1'b1;
            end
            2: begin
               // every glyph wraps and scrolls
               s = '{16'h0000, 16'hFFFF, 10'd0, 6'd1, 6'd1, 11'd1, 11'd1, 1'b1};
               count    = 150;
               pause_at = 75;
            end
            3: begin
               s = '{16'hFFFF, 16'h0000, 10'd1023, 6'd63, 6'd63, SCREEN_MAX, SCREEN_MAX, 1'b0};
               count = 150;
            end
            4: begin
               // oversized screen registers clamp to the maximum
               s = '{16'h1234, 16'hFEDC, 10'd5, 6'd7, 6'd9, 11'd2047, 11'd2047, 1'b0};
               count = 150;
            end
            5: begin
               // zero width wraps after every glyph
               s = '{16'hA5A5, 16'h5A5A, 10'd3, 6'd2, 6'd4, 11'd0, 11'd30, 1'b1};
               count = 150;
            end
            default: s = roll_setup();
         endcase
         if (ph == NUM_PHASES - 1)
            idle_on = 1'b0;
         apply_setup(s);
         feed_random(count, pause_at);
         end_phase();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d bytes across %0d register setups, incl. long result hold-off",
               bytes_sent, setups_used);
      $display("checked %0d glyph draws and %0d scrolls, %0d mismatches",
               draws_seen, scrolls_seen, err_cnt);
      if (err_cnt == 0 && awaited_ops.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
